// ===== rtl/fdstr_pkg.sv =====
// Shared types, constants and helper functions of the float to decimal string converter.
package fdstr_pkg;

    // Default number of fraction digits and default depth of the work queue.
    localparam int FRAC_DIGITS_DEF = 6;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Field widths. The fraction digit value is kept wide enough for nine digits.
    localparam int BITS_W  = 32;
    localparam int IPART_W = 31;
    localparam int FDIG_W  = 30;
    localparam int SIG_W   = 24;
    localparam int CHAR_W  = 8;
    localparam int SPACE_W = 8;

    // IEEE single decoding constants.
    localparam logic [7:0]  EXP_ALL_ONES = 8'hff;
    localparam logic [7:0]  EXP_POINT    = 8'd150;
    localparam logic [7:0]  EXP_LIMIT    = 8'd158;
    localparam logic [7:0]  SPACE_MIN    = 8'd9;
    localparam logic [7:0]  SPACE_RESET  = 8'd32;

    // Multiply by this and shift right by DIV10_SHIFT to divide a 32-bit value by ten.
    localparam logic [31:0] DIV10_MAGIC = 32'hcccc_cccd;
    localparam int          DIV10_SHIFT = 35;

    // ASCII codes.
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // One classified conversion waiting for digit generation.
    typedef struct packed {
        logic               err;
        logic               sign;
        logic [IPART_W-1:0] ipart;
        logic [FDIG_W-1:0]  fdig;
    } entry_t;

    function automatic logic [FDIG_W-1:0] pow10(input int n);
        logic [FDIG_W-1:0] p;
        p = FDIG_W'(1);
        for (int i = 0; i < n; i++)
        begin
            p = FDIG_W'(p * FDIG_W'(10));
        end
        return p;
    endfunction

endpackage

// ===== rtl/fdstr_front.sv =====
// Front end: accepts input words, classifies them and forms integer part and fraction digits.
module fdstr_front import fdstr_pkg::*; #(
    parameter int FRACTION_DIGITS = FRAC_DIGITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [SPACE_W-1:0] space,
    input  logic               push,
    input  logic [BITS_W-1:0]  float_bits,
    output logic               full,
    output logic               q_push,
    input  logic               q_ready,
    output entry_t             q_entry
);

    localparam logic [FDIG_W-1:0] P10 = pow10(FRACTION_DIGITS);
    localparam int PROD_W = SIG_W + FDIG_W;

    // Stage A holds the raw word, stage B the decoded parts, stage C the scaled fraction.
    logic                a_valid_reg;
    logic [BITS_W-1:0]   a_bits_reg;
    logic                b_valid_reg;
    logic                b_err_reg;
    logic                b_sign_reg;
    logic [IPART_W-1:0]  b_ipart_reg;
    logic [SIG_W-1:0]    b_frac_reg;
    logic [7:0]          b_rsh_reg;
    logic                c_valid_reg;
    logic                c_err_reg;
    logic                c_sign_reg;
    logic [IPART_W-1:0]  c_ipart_reg;
    logic [PROD_W-1:0]   c_prod_reg;
    logic [7:0]          c_rsh_reg;

    logic                c_free;
    logic                b_free;
    logic                a_free;
    logic                accept;

    logic [7:0]          expo;
    logic [SIG_W-1:0]    sig;
    logic [7:0]          lsh;
    logic [7:0]          rsh;
    logic                d_err;
    logic [IPART_W-1:0]  d_ipart;
    logic [SIG_W-1:0]    d_frac;
    logic [7:0]          d_rsh;
    logic [PROD_W-1:0]   shifted;

    assign c_free = !c_valid_reg || q_ready;
    assign b_free = !b_valid_reg || c_free;
    assign a_free = !a_valid_reg || b_free;
    assign full   = !a_free;
    assign accept = push && a_free;

    // Decode of the held word.
    always_comb
    begin
        expo    = a_bits_reg[30:23];
        sig     = {1'b1, a_bits_reg[22:0]};
        lsh     = expo - EXP_POINT;
        rsh     = EXP_POINT - expo;
        d_err   = (space < SPACE_MIN) || (expo == EXP_ALL_ONES) || (expo >= EXP_LIMIT);
        d_ipart = '0;
        d_frac  = '0;
        d_rsh   = '0;
        if (expo >= EXP_POINT)
        begin
            d_ipart = {{(IPART_W-SIG_W){1'b0}}, sig} << lsh[2:0];
        end
        else if (rsh < 8'd24)
        begin
            d_ipart = IPART_W'(sig >> rsh[4:0]);
            d_frac  = sig & ~({SIG_W{1'b1}} << rsh[4:0]);
            d_rsh   = rsh;
        end
        else
        begin
            d_frac  = sig;
            d_rsh   = rsh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
            begin
                a_valid_reg <= push;
            end
            if (b_free)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_free)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_bits_reg <= float_bits;
        end
        if (b_free && a_valid_reg)
        begin
            b_err_reg   <= d_err;
            b_sign_reg  <= a_bits_reg[31];
            b_ipart_reg <= d_ipart;
            b_frac_reg  <= d_frac;
            b_rsh_reg   <= d_rsh;
        end
        if (c_free && b_valid_reg)
        begin
            c_err_reg   <= b_err_reg;
            c_sign_reg  <= b_sign_reg;
            c_ipart_reg <= b_ipart_reg;
            c_prod_reg  <= PROD_W'(b_frac_reg) * PROD_W'(P10);
            c_rsh_reg   <= b_rsh_reg;
        end
    end

    // The product stays below 2^54, so a shift of 54 or more correctly yields zero.
    assign shifted = c_prod_reg >> c_rsh_reg;

    assign q_push        = c_valid_reg && q_ready;
    assign q_entry.err   = c_err_reg;
    assign q_entry.sign  = c_sign_reg;
    assign q_entry.ipart = c_ipart_reg;
    assign q_entry.fdig  = shifted[FDIG_W-1:0];

endmodule

// ===== rtl/fdstr_queue.sv =====
// Short queue that decouples the front end from the character generator.
module fdstr_queue import fdstr_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   ready,
    output logic   valid,
    input  logic   pop,
    output entry_t pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign ready     = (count_reg != CNT_W'(DEPTH));
    assign valid     = (count_reg != '0);
    assign do_push   = push && ready;
    assign do_pop    = pop && valid;
    assign pop_entry = slots[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/fdstr_back.sv =====
// Back end: turns one classified conversion into ASCII characters and hands them out.
module fdstr_back import fdstr_pkg::*; #(
    parameter int FRACTION_DIGITS = FRAC_DIGITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  entry_t            q_entry,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_pop,
    output logic [CHAR_W-1:0] out_char,
    output logic              out_last,
    output logic              out_err
);

    localparam int MAX_CHARS = 12 + FRACTION_DIGITS;
    localparam int IDX_W     = $clog2(MAX_CHARS);
    localparam int POS_W     = $clog2(MAX_CHARS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FRAC,
        S_DOT,
        S_INT,
        S_SIGN,
        S_EMIT,
        S_ERR
    } state_t;

    state_t              state_reg, state_next;
    logic [31:0]         x_reg, x_next;
    logic [IPART_W-1:0]  ip_reg, ip_next;
    logic                sign_reg, sign_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]   out_char_reg, out_char_next;
    logic                out_last_reg, out_last_next;
    logic                out_err_reg, out_err_next;

    // The string is built back to front in the store and read out from the top down.
    logic [CHAR_W-1:0]   char_store [MAX_CHARS];
    logic                wr_en;
    logic [CHAR_W-1:0]   wr_data;
    logic [POS_W-1:0]    pos_dec;
    logic [CHAR_W-1:0]   rd_data;

    logic [63:0]         div_prod;
    logic [28:0]         quot;
    logic [31:0]         rem_full;
    logic [CHAR_W-1:0]   digit_char;
    logic                out_free;

    assign div_prod   = 64'(x_reg) * 64'(DIV10_MAGIC);
    assign quot       = div_prod[63:DIV10_SHIFT];
    assign rem_full   = x_reg - 32'({3'b000, quot} * 32'd10);
    assign digit_char = CH_ZERO + {4'b0000, rem_full[3:0]};
    assign out_free   = !out_valid_reg || out_pop;
    assign pos_dec    = pos_reg - 1'b1;
    assign rd_data    = char_store[pos_dec[IDX_W-1:0]];

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        ip_next        = ip_reg;
        sign_next      = sign_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !out_pop;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        wr_data        = digit_char;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    x_next    = 32'(q_entry.fdig);
                    ip_next   = q_entry.ipart;
                    sign_next = q_entry.sign;
                    pos_next  = '0;
                    state_next = q_entry.err ? S_ERR : S_FRAC;
                end
            end
            S_FRAC:
            begin
                wr_en    = 1'b1;
                x_next   = 32'(quot);
                pos_next = pos_reg + 1'b1;
                if (pos_reg == POS_W'(FRACTION_DIGITS - 1))
                begin
                    state_next = S_DOT;
                end
            end
            S_DOT:
            begin
                wr_en      = 1'b1;
                wr_data    = CH_DOT;
                pos_next   = pos_reg + 1'b1;
                x_next     = 32'(ip_reg);
                state_next = S_INT;
            end
            S_INT:
            begin
                // At least one integer digit is written, so zero gives a single '0'.
                wr_en    = 1'b1;
                x_next   = 32'(quot);
                pos_next = pos_reg + 1'b1;
                if (quot == '0)
                begin
                    state_next = S_SIGN;
                end
            end
            S_SIGN:
            begin
                if (sign_reg)
                begin
                    wr_en    = 1'b1;
                    wr_data  = CH_MINUS;
                    pos_next = pos_reg + 1'b1;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = rd_data;
                    out_last_next  = (pos_reg == POS_W'(1));
                    out_err_next   = 1'b0;
                    pos_next       = pos_dec;
                    if (pos_reg == POS_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CH_NUL;
                    out_last_next  = 1'b1;
                    out_err_next   = 1'b1;
                    pos_next       = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            x_reg         <= '0;
            ip_reg        <= '0;
            sign_reg      <= 1'b0;
            out_char_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            x_reg         <= x_next;
            ip_reg        <= ip_next;
            sign_reg      <= sign_next;
            out_char_reg  <= out_char_next;
            out_last_reg  <= out_last_next;
            out_err_reg   <= out_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            char_store[pos_reg[IDX_W-1:0]] <= wr_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;
    assign out_err   = out_err_reg;

endmodule

// ===== rtl/float_to_decimal_string.sv =====
// Top level of the IEEE single to fixed-point decimal string converter.
// Each accepted word yields its text one ASCII character per result: an optional '-', the
// truncated integer digits, '.', and FRACTION_DIGITS truncated fraction digits, with
// last_char on the final one; infinity, NaN, magnitudes of 2^31 or more, and a
// space_available below 9 give a single result with error set and text_char zero. A
// three-stage front end decodes the word and scales the fraction with one multiplier, then
// queues it; the character generator works through one queued conversion at a time with a
// shared divide-by-ten unit, one digit per cycle. It writes the fraction digits, the '.',
// the integer digits and any '-' into its store, then hands the characters out at one
// character per cycle when results are popped without stalls; an error conversion skips
// digit generation. Front-end decoding of later words overlaps this.
module float_to_decimal_string import fdstr_pkg::*; #(
    parameter int FRACTION_DIGITS = FRAC_DIGITS_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [SPACE_W-1:0] space_available,
    input  logic               push,
    output logic               full,
    input  logic [BITS_W-1:0]  float_bits,
    output logic               empty,
    input  logic               pop,
    output logic [CHAR_W-1:0]  text_char,
    output logic               last_char,
    output logic               error
);

    logic [SPACE_W-1:0] space_reg;
    logic               fq_push;
    logic               fq_ready;
    entry_t             fq_entry;
    logic               bq_valid;
    logic               bq_pop;
    entry_t             bq_entry;
    logic               out_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            space_reg <= SPACE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            space_reg <= space_available;
        end
    end

    fdstr_front #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .space      (space_reg),
        .push       (push),
        .float_bits (float_bits),
        .full       (full),
        .q_push     (fq_push),
        .q_ready    (fq_ready),
        .q_entry    (fq_entry)
    );

    fdstr_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fq_push),
        .push_entry (fq_entry),
        .ready      (fq_ready),
        .valid      (bq_valid),
        .pop        (bq_pop),
        .pop_entry  (bq_entry)
    );

    fdstr_back #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (bq_valid),
        .q_entry   (bq_entry),
        .q_pop     (bq_pop),
        .out_valid (out_valid),
        .out_pop   (pop),
        .out_char  (text_char),
        .out_last  (last_char),
        .out_err   (error)
    );

    assign empty = !out_valid;

    // An error transaction is always a lone, final, blank character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && error) |-> (last_char && text_char == CH_NUL))
        else $error("error result without last_char or with nonzero text");

    // Within a conversion the next character follows the popped one without a gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_char) |=> !empty)
        else $error("gap inside a conversion");

    // A character that is not taken stays on the ports unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(text_char) && $stable(last_char)))
        else $error("waiting result changed");

endmodule
